### design/wgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgb_pkg
// Shared constants and types of the write-gather burst buffer.
// ----------------------------------------------------------------------------
package wgb_pkg;

    localparam int DEFAULT_BUFFER_BYTES = 128;
    localparam int LANES                = 8;
    localparam int BURST_BYTES          = 32;
    localparam int BEATS_PER_BURST      = 4;
    localparam int BEAT_W               = 2;
    localparam int FILL_W               = 6;
    localparam int LEFT_W               = 5;
    localparam int CMD_DEPTH            = 2;
    localparam int PADDR_W              = 3;
    localparam int S_TDATA_W            = 64;
    localparam int S_TUSER_W            = 2;
    localparam int M_TDATA_W            = 104;

    localparam logic [31:0] ADDR_ALIGN_MASK    = 32'hFFFF_FFE0;
    localparam logic [0:0]  REG_GATHER_ADDRESS = 1'b0;

    typedef enum logic [1:0] {
        SIZE_BYTE   = 2'd0,
        SIZE_HALF   = 2'd1,
        SIZE_WORD   = 2'd2,
        SIZE_DOUBLE = 2'd3
    } store_size_t;

    typedef struct packed {
        logic [LEFT_W-1:0] bytes_left;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

### design/write_gather_burst_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// write_gather_burst_buffer
// Write-gather pipe: CPU stores of 1, 2, 4 or 8 bytes enter the slave stream
// one word per cycle and are appended big-endian to a circular byte buffer.
// Once a store leaves 32 or more bytes held, 32 bytes leave on the master
// stream as four 64-bit beats tagged with the gather address (low five bits
// cleared); tlast marks the fourth beat, bytes_left the bytes still held.
// Throughput, unless stalled: one store per cycle; beats leave at one per
// cycle, one buffer row read per beat from the lane-split byte store.
// Path: a burst's command passes the command queue, the beat issuer, the row
// read stage and the output register, and its four beats leave in order.
// Stall: while m_tready is low the output word holds; queued bursts wait and
// s_tready drops when the command queue is full or the buffer lacks room
// for another doubleword. The gather address is written over APB at byte
// address 0. Reset empties the buffer and clears the address; the byte store
// needs no clearing pass, s_tready is high right after reset.
// ----------------------------------------------------------------------------
module write_gather_burst_buffer #(
    parameter int BUFFER_BYTES = wgb_pkg::DEFAULT_BUFFER_BYTES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wgb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // [63:0] write_data
    input  wire logic [wgb_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  wire logic [wgb_pkg::S_TUSER_W-1:0] s_tuser,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] burst_address, [95:32] beat_data, [100:96] bytes_left, [103:101] zero
    output      logic [wgb_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic                          m_tlast
);

    localparam int ROWS  = BUFFER_BYTES / wgb_pkg::LANES;
    localparam int ROW_W = $clog2(ROWS);

    logic [31:0] gather_address_reg, gather_address_next;
    logic        cfg_write;

    logic [wgb_pkg::LANES-1:0] wr_en;
    logic [ROW_W-1:0]          wr_row  [wgb_pkg::LANES];
    logic [7:0]                wr_data [wgb_pkg::LANES];
    logic                      rd_en;
    logic [ROW_W-1:0]          rd_row;
    logic [7:0]                rd_data [wgb_pkg::LANES];

    wgb_pkg::queue_status_t    q_status;
    wgb_pkg::cmd_t             push_cmd;
    wgb_pkg::cmd_t             pop_cmd;
    logic                      push;
    logic                      pop;

    logic [31:0]               burst_address;
    logic [63:0]               beat_data;
    logic [wgb_pkg::LEFT_W-1:0] bytes_left;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == wgb_pkg::REG_GATHER_ADDRESS);
    assign gather_address_next = cfg_write ? pwdata : gather_address_reg;
    assign prdata    = (paddr[2] == wgb_pkg::REG_GATHER_ADDRESS) ? gather_address_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_address_reg <= '0;
        end
        else
        begin
            gather_address_reg <= gather_address_next;
        end
    end

    wgb_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tuser),
        .write_data (s_tdata),
        .wr_en      (wr_en),
        .wr_row     (wr_row),
        .wr_data    (wr_data),
        .beat_read  (rd_en),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    wgb_byte_store #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    wgb_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    wgb_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .pop_cmd        (pop_cmd),
        .pop            (pop),
        .rd_en          (rd_en),
        .rd_row         (rd_row),
        .rd_data        (rd_data),
        .gather_address (gather_address_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .burst_address  (burst_address),
        .beat_data      (beat_data),
        .last_beat      (m_tlast),
        .bytes_left     (bytes_left)
    );

    assign m_tdata = {3'b000, bytes_left, beat_data, burst_address};

endmodule
`default_nettype wire

### design/wgb_byte_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgb_byte_store
// Byte buffer split into eight byte lanes, one write port per lane and a
// common registered row read.
// ----------------------------------------------------------------------------
module wgb_byte_store #(
    parameter int BUFFER_BYTES = wgb_pkg::DEFAULT_BUFFER_BYTES,
    localparam int ROWS  = BUFFER_BYTES / wgb_pkg::LANES,
    localparam int ROW_W = $clog2(ROWS)
) (
    input  wire logic                     clk,
    input  wire logic [wgb_pkg::LANES-1:0] wr_en,
    input  wire logic [ROW_W-1:0]         wr_row  [wgb_pkg::LANES],
    input  wire logic [7:0]               wr_data [wgb_pkg::LANES],
    input  wire logic                     rd_en,
    input  wire logic [ROW_W-1:0]         rd_row,
    output      logic [7:0]               rd_data [wgb_pkg::LANES]
);

    logic [7:0] byte_mem    [wgb_pkg::LANES][ROWS];
    logic [7:0] rd_data_reg [wgb_pkg::LANES];

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < wgb_pkg::LANES; l++)
        begin
            if (wr_en[l])
            begin
                byte_mem[l][wr_row[l]] <= wr_data[l];
            end
            if (rd_en)
            begin
                rd_data_reg[l] <= byte_mem[l][rd_row];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### design/wgb_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgb_cmd_queue
// Short queue of burst commands between the store front and the beat back.
// ----------------------------------------------------------------------------
module wgb_cmd_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire wgb_pkg::cmd_t          push_cmd,
    input  wire logic                   pop,
    output      wgb_pkg::cmd_t          pop_cmd,
    output      wgb_pkg::queue_status_t status
);

    localparam int DEPTH = wgb_pkg::CMD_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wgb_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd      = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule
`default_nettype wire

### design/wgb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgb_front
// Takes stores, scatters their bytes over the lanes big-endian, tracks the
// gather fill level and queues a burst command when 32 bytes are held.
// ----------------------------------------------------------------------------
module wgb_front #(
    parameter int BUFFER_BYTES = wgb_pkg::DEFAULT_BUFFER_BYTES,
    localparam int ROWS  = BUFFER_BYTES / wgb_pkg::LANES,
    localparam int ROW_W = $clog2(ROWS),
    localparam int OCC_W = $clog2(BUFFER_BYTES + 1)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_ready,
    input  wire logic [1:0]               func,
    input  wire logic [63:0]              write_data,
    output      logic [wgb_pkg::LANES-1:0] wr_en,
    output      logic [ROW_W-1:0]         wr_row  [wgb_pkg::LANES],
    output      logic [7:0]               wr_data [wgb_pkg::LANES],
    input  wire logic                     beat_read,
    input  wire wgb_pkg::queue_status_t   q_status,
    output      logic                     push,
    output      wgb_pkg::cmd_t            push_cmd
);

    localparam int FILL_W = wgb_pkg::FILL_W;

    logic [2:0]        wr_lane_reg, wr_lane_next;
    logic [ROW_W-1:0]  wr_row_reg, wr_row_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    logic              accept;
    logic [3:0]        nbytes;
    logic [3:0]        lane_sum;
    logic [ROW_W-1:0]  row_inc;
    logic [FILL_W-1:0] fill_sum;
    logic              burst;
    logic [2:0]        lane_k [wgb_pkg::LANES];
    logic [2:0]        lane_j [wgb_pkg::LANES];

    always_comb
    begin
        unique case (func)
            wgb_pkg::SIZE_BYTE:   nbytes = 4'd1;
            wgb_pkg::SIZE_HALF:   nbytes = 4'd2;
            wgb_pkg::SIZE_WORD:   nbytes = 4'd4;
            wgb_pkg::SIZE_DOUBLE: nbytes = 4'd8;
            default:              nbytes = 4'd1;
        endcase
    end

    // keep room for a full doubleword behind the oldest unread beat
    assign in_ready = (occ_reg <= OCC_W'(BUFFER_BYTES - wgb_pkg::LANES)) && !q_status.full;
    assign accept   = in_valid && in_ready;
    assign row_inc  = (wr_row_reg == ROW_W'(ROWS - 1)) ? '0 : wr_row_reg + 1'b1;
    assign lane_sum = {1'b0, wr_lane_reg} + nbytes;

    always_comb
    begin
        for (int l = 0; l < wgb_pkg::LANES; l++)
        begin
            // k: byte order within the store, j: byte index within write_data
            lane_k[l]  = 3'(l) - wr_lane_reg;
            lane_j[l]  = 3'(nbytes - 4'd1) - lane_k[l];
            wr_en[l]   = accept && ({1'b0, lane_k[l]} < nbytes);
            wr_row[l]  = (3'(l) < wr_lane_reg) ? row_inc : wr_row_reg;
            wr_data[l] = write_data[{lane_j[l], 3'b000} +: 8];
        end
    end

    assign fill_sum            = fill_reg + FILL_W'(nbytes);
    assign burst               = (fill_sum >= FILL_W'(wgb_pkg::BURST_BYTES));
    assign push                = accept && burst;
    assign push_cmd.bytes_left = wgb_pkg::LEFT_W'(fill_sum - FILL_W'(wgb_pkg::BURST_BYTES));

    always_comb
    begin
        wr_lane_next = wr_lane_reg;
        wr_row_next  = wr_row_reg;
        fill_next    = fill_reg;
        if (accept)
        begin
            wr_lane_next = lane_sum[2:0];
            if (lane_sum[3])
            begin
                wr_row_next = row_inc;
            end
            fill_next = burst ? fill_sum - FILL_W'(wgb_pkg::BURST_BYTES) : fill_sum;
        end
        occ_next = occ_reg
                 + (accept ? OCC_W'(nbytes) : '0)
                 - (beat_read ? OCC_W'(wgb_pkg::LANES) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_lane_reg <= '0;
            wr_row_reg  <= '0;
            fill_reg    <= '0;
            occ_reg     <= '0;
        end
        else
        begin
            wr_lane_reg <= wr_lane_next;
            wr_row_reg  <= wr_row_next;
            fill_reg    <= fill_next;
            occ_reg     <= occ_next;
        end
    end

    a_read_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        beat_read |-> occ_reg >= OCC_W'(wgb_pkg::LANES))
        else $error("beat read with fewer than eight bytes held");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(BUFFER_BYTES))
        else $error("byte buffer overrun");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(wgb_pkg::BURST_BYTES))
        else $error("fill level left at a full burst");

    a_fill_in_occ: assert property (@(posedge clk) disable iff (!rst_n)
        OCC_W'(fill_reg) <= occ_reg)
        else $error("gather fill exceeds bytes held in the buffer");

endmodule
`default_nettype wire

### design/wgb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgb_back
// Pops burst commands and reads four rows per burst, one beat a cycle
// while out_ready allows, through a read stage and an output register.
// ----------------------------------------------------------------------------
module wgb_back #(
    parameter int BUFFER_BYTES = wgb_pkg::DEFAULT_BUFFER_BYTES,
    localparam int ROWS  = BUFFER_BYTES / wgb_pkg::LANES,
    localparam int ROW_W = $clog2(ROWS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire wgb_pkg::queue_status_t      q_status,
    input  wire wgb_pkg::cmd_t               pop_cmd,
    output      logic                        pop,
    output      logic                        rd_en,
    output      logic [ROW_W-1:0]            rd_row,
    input  wire logic [7:0]                  rd_data [wgb_pkg::LANES],
    input  wire logic [31:0]                 gather_address,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      logic [31:0]                 burst_address,
    output      logic [63:0]                 beat_data,
    output      logic                        last_beat,
    output      logic [wgb_pkg::LEFT_W-1:0]  bytes_left
);

    localparam int BEAT_W = wgb_pkg::BEAT_W;
    localparam int LEFT_W = wgb_pkg::LEFT_W;

    logic              active_reg, active_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;
    logic [LEFT_W-1:0] left_reg;
    logic [ROW_W-1:0]  rd_row_reg, rd_row_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg;
    logic [LEFT_W-1:0] s1_left_reg;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_addr_reg;
    logic [63:0]       out_data_reg;
    logic              out_last_reg;
    logic [LEFT_W-1:0] out_left_reg;

    logic s1_move;
    logic issue;
    logic final_beat;

    assign s1_move    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign issue      = active_reg && (!s1_valid_reg || s1_move);
    assign final_beat = (beat_reg == BEAT_W'(wgb_pkg::BEATS_PER_BURST - 1));
    assign pop        = !q_status.empty && (!active_reg || (issue && final_beat));

    always_comb
    begin
        active_next    = pop ? 1'b1 : ((issue && final_beat) ? 1'b0 : active_reg);
        beat_next      = issue ? beat_reg + 1'b1 : beat_reg;
        rd_row_next    = rd_row_reg;
        if (issue)
        begin
            rd_row_next = (rd_row_reg == ROW_W'(ROWS - 1)) ? '0 : rd_row_reg + 1'b1;
        end
        s1_valid_next  = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            beat_reg      <= '0;
            rd_row_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            beat_reg      <= beat_next;
            rd_row_reg    <= rd_row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            left_reg <= pop_cmd.bytes_left;
        end
        if (issue)
        begin
            s1_last_reg <= final_beat;
            s1_left_reg <= left_reg;
        end
        if (s1_move)
        begin
            out_addr_reg <= gather_address & wgb_pkg::ADDR_ALIGN_MASK;
            out_last_reg <= s1_last_reg;
            out_left_reg <= s1_left_reg;
            // lane 0 holds the earliest byte of the row
            for (int l = 0; l < wgb_pkg::LANES; l++)
            begin
                out_data_reg[(wgb_pkg::LANES - 1 - l) * 8 +: 8] <= rd_data[l];
            end
        end
    end

    assign rd_en         = issue;
    assign rd_row        = rd_row_reg;
    assign out_valid     = out_valid_reg;
    assign burst_address = out_addr_reg;
    assign beat_data     = out_data_reg;
    assign last_beat     = out_last_reg;
    assign bytes_left    = out_left_reg;

endmodule
`default_nettype wire

### test/write_gather_burst_buffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// write_gather_burst_buffer_tb
// Drives 1/2/4/8-byte stores into the gather pipe and checks every burst word
// against a byte-queue model: address alignment, big-endian byte order,
// tlast on the fourth word and the bytes still held after each burst.
// ----------------------------------------------------------------------------
module write_gather_burst_buffer_tb;

    typedef struct {
        logic [31:0] addr;
        logic [63:0] data;
        logic        last;
        logic [4:0]  left;
    } burst_word_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [wgb_pkg::PADDR_W-1:0]     paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            s_tvalid;
    logic                            s_tready;
    // [63:0] write_data
    logic [wgb_pkg::S_TDATA_W-1:0]   s_tdata;
    // [1:0] func
    logic [wgb_pkg::S_TUSER_W-1:0]   s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    // [31:0] burst_address, [95:32] beat_data, [100:96] bytes_left, [103:101] zero
    logic [wgb_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;

    // model of the gather pipe
    logic [7:0]     held_bytes[$];
    logic [31:0]    gather_addr;
    burst_word_t    pending_words[$];

    int err_count;
    int stores_sent;
    int words_seen;
    int bursts_seen;
    int addr_writes;
    int input_stalls;
    int src_max_gap;
    int snk_max_stall;
    int snk_wait;
    int hold_off_left;

    write_gather_burst_buffer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // append one store big-endian and queue a burst once 32 bytes are held
    function automatic void gather_store(input wgb_pkg::store_size_t size,
                                         input logic [63:0] value);
        int          nbytes;
        int          left;
        logic [63:0] word;
        burst_word_t bw;
        nbytes = 1 << size;
        for (int i = 0; i < nbytes; i++)
            held_bytes.push_back(value[8*(nbytes-1-i) +: 8]);
        if (held_bytes.size() >= wgb_pkg::BURST_BYTES)
        begin
            left = held_bytes.size() - wgb_pkg::BURST_BYTES;
            for (int beat = 0; beat < wgb_pkg::BEATS_PER_BURST; beat++)
            begin
                word = '0;
                for (int i = 0; i < 8; i++)
                    word = {word[55:0], held_bytes.pop_front()};
                bw.addr = gather_addr & wgb_pkg::ADDR_ALIGN_MASK;
                bw.data = word;
                bw.last = (beat == wgb_pkg::BEATS_PER_BURST - 1);
                bw.left = left[4:0];
                pending_words.push_back(bw);
            end
        end
    endfunction

    task automatic send_store(input wgb_pkg::store_size_t size, input logic [63:0] value);
        int gap;
        gap = $urandom_range(src_max_gap, 0);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= size;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gather_store(size, value);
        stores_sent++;
    endtask

    task automatic send_random_store(input wgb_pkg::store_size_t size);
        send_store(size, {$urandom, $urandom});
    endtask

    task automatic apb_write_addr(input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {wgb_pkg::REG_GATHER_ADDRESS, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        gather_addr = value;
        addr_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_addr_check();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {wgb_pkg::REG_GATHER_ADDRESS, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== gather_addr)
        begin
            $error("gather_address readback: expected %h, got %h", gather_addr, prdata);
            err_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop offering stores, wait for every queued word, then the pipeline latency
    task automatic wait_for_drain();
        int n;
        @(negedge clk);
        s_tvalid <= 1'b0;
        for (n = 0; n < 20000 && pending_words.size() != 0; n++)
            @(posedge clk);
        if (pending_words.size() != 0)
        begin
            $error("%0d burst words never arrived", pending_words.size());
            err_count++;
            pending_words.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_gather_addr(input logic [31:0] value);
        wait_for_drain();
        apb_write_addr(value);
        apb_read_addr_check();
    endtask

    // all sizes, data extremes, ignored upper bits, bursts leaving 0 and 7 bytes
    task automatic test_directed_stores();
        src_max_gap   = 13;
        snk_max_stall = 13;
        apb_read_addr_check();
        set_gather_addr(32'hFFFF_FFFF);
        send_store(wgb_pkg::SIZE_DOUBLE, 64'h0123_4567_89AB_CDEF);
        send_store(wgb_pkg::SIZE_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_store(wgb_pkg::SIZE_DOUBLE, 64'h0000_0000_0000_0000);
        send_store(wgb_pkg::SIZE_DOUBLE, 64'h8000_0000_0000_0001);
        send_store(wgb_pkg::SIZE_BYTE,   64'hFFFF_FFFF_FFFF_FF00);
        send_store(wgb_pkg::SIZE_BYTE,   64'h0000_0000_0000_00FF);
        send_store(wgb_pkg::SIZE_HALF,   64'hFFFF_FFFF_FFFF_0000);
        send_store(wgb_pkg::SIZE_HALF,   64'h0000_0000_0000_FFFF);
        send_store(wgb_pkg::SIZE_WORD,   64'hFFFF_FFFF_0000_0000);
        send_store(wgb_pkg::SIZE_WORD,   64'h0000_0000_DEAD_BEEF);
        send_store(wgb_pkg::SIZE_DOUBLE, 64'hA5A5_5A5A_C3C3_3C3C);
        send_store(wgb_pkg::SIZE_WORD,   64'h1122_3344_5566_7788);
        send_store(wgb_pkg::SIZE_HALF,   64'h0000_0000_0000_8001);
        send_store(wgb_pkg::SIZE_HALF,   64'hFFFF_FFFF_FFFF_7FFE);
        send_store(wgb_pkg::SIZE_BYTE,   64'h0000_0000_0000_0080);
        send_store(wgb_pkg::SIZE_DOUBLE, 64'hFEDC_BA98_7654_3210);
    endtask

    task automatic test_address_extremes();
        logic [31:0] settings[3];
        settings[0] = 32'h0000_001F;
        settings[1] = 32'hFFFF_FFE0;
        settings[2] = 32'h0000_0000;
        foreach (settings[k])
        begin
            set_gather_addr(settings[k]);
            repeat (4) send_random_store(wgb_pkg::SIZE_DOUBLE);
        end
    endtask

    // phases: both sides idle, no idling, sender idles only, receiver stalls only
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            src_max_gap   = (phase == 0 || phase == 2) ? 13 : 0;
            snk_max_stall = (phase == 0 || phase == 3) ? 13 : 0;
            set_gather_addr($urandom);
            repeat (28)
                send_random_store(wgb_pkg::store_size_t'($urandom_range(3, 0)));
        end
    endtask

    // receiver holds off long enough that the buffer fills and s_tready drops
    task automatic test_input_backpressure();
        set_gather_addr($urandom);
        src_max_gap   = 0;
        snk_max_stall = 0;
        @(posedge clk);
        hold_off_left = 400;
        repeat (30) send_random_store(wgb_pkg::SIZE_DOUBLE);
    endtask

    // receiver side: per-word stall plus the long hold-off
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_tready <= 1'b0;
            hold_off_left--;
        end
        else if (snk_wait > 0)
        begin
            m_tready <= 1'b0;
            snk_wait--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : burst_check
        burst_word_t want;
        if (rst_n)
        begin
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (m_tvalid && m_tready)
            begin
                words_seen++;
                if (m_tlast)
                    bursts_seen++;
                snk_wait = $urandom_range(snk_max_stall, 0);
                if (pending_words.size() == 0)
                begin
                    $error("unexpected burst word: tdata %h tlast %b", m_tdata, m_tlast);
                    err_count++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (m_tdata[31:0] !== want.addr)
                    begin
                        $error("burst_address: expected %h, got %h", want.addr, m_tdata[31:0]);
                        err_count++;
                    end
                    if (m_tdata[95:32] !== want.data)
                    begin
                        $error("beat_data: expected %h, got %h", want.data, m_tdata[95:32]);
                        err_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_beat: expected %b, got %b", want.last, m_tlast);
                        err_count++;
                    end
                    if (m_tdata[100:96] !== want.left)
                    begin
                        $error("bytes_left: expected %0d, got %0d", want.left, m_tdata[100:96]);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("write_gather_burst_buffer regression: fail");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        gather_addr   = '0;
        err_count     = 0;
        stores_sent   = 0;
        words_seen    = 0;
        bursts_seen   = 0;
        addr_writes   = 0;
        input_stalls  = 0;
        src_max_gap   = 0;
        snk_max_stall = 0;
        snk_wait      = 0;
        hold_off_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_stores();
        test_address_extremes();
        test_random_traffic();
        test_input_backpressure();
        wait_for_drain();

        $display("stores sent %0d, burst words checked %0d in %0d bursts",
                 stores_sent, words_seen, bursts_seen);
        $display("gather address written %0d times, input held off for %0d cycles",
                 addr_writes, input_stalls);
        if (err_count == 0)
            $display("write_gather_burst_buffer regression: pass");
        else
            $display("write_gather_burst_buffer regression: fail");
        $finish;
    end

endmodule
